// ===== rtl/core/serial_marker_substituter_top_macros.svh =====
// Assertion macros shared by the serial marker substituter RTL.
`ifndef SERIAL_MARKER_SUBSTITUTER_TOP_MACROS_SVH
`define SERIAL_MARKER_SUBSTITUTER_TOP_MACROS_SVH

// Plain property check on clk, off during reset.
`define SMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define SMS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sms_pkg.sv =====
// Shared types, constants and functions of the serial marker substituter.
package sms_pkg;

    localparam int MARKER_WORDS = 8;
    localparam int IDX_W        = $clog2(MARKER_WORDS);
    localparam int WORD_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 16;
    localparam int CODE_W       = 5;
    localparam int SERIAL_W     = 64;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic REG_CODE_BITS = 1'b0;
    localparam logic REG_SERIAL    = 1'b1;

    // Supported code widths
    localparam logic [CODE_W-1:0] CODE_13 = 5'd13;
    localparam logic [CODE_W-1:0] CODE_14 = 5'd14;
    localparam logic [CODE_W-1:0] CODE_15 = 5'd15;
    localparam logic [CODE_W-1:0] CODE_16 = 5'd16;

    // Marker high bytes per width
    localparam logic [BYTE_W-1:0] MARKER_HI_13 = 8'h01;
    localparam logic [BYTE_W-1:0] MARKER_HI_15 = 8'h02;
    localparam logic [BYTE_W-1:0] MARKER_HI_16 = 8'h0F;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // One classified image word on its way to the back end
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              match_en;
        logic [BYTE_W-1:0] marker_hi;
    } sms_entry_t;

    // Low byte of marker word at a window position
    function automatic logic [BYTE_W-1:0] marker_letter(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] letter;
        unique case (idx)
            3'd0: letter = 8'h46;
            3'd1: letter = 8'h50;
            3'd2: letter = 8'h53;
            3'd3: letter = 8'h45;
            3'd4: letter = 8'h52;
            3'd5: letter = 8'h49;
            3'd6: letter = 8'h41;
            3'd7: letter = 8'h4C;
            default: letter = 8'h00;
        endcase
        return letter;
    endfunction

endpackage

// ===== rtl/core/sms_front.sv =====
// Front end: accepts image beats and tags each word with the active marker.
module sms_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sms_pkg::WORD_W-1:0]       s_tdata,   // [15:0] code_word
    input  logic                             s_tlast,   // end_of_image
    input  logic [sms_pkg::CODE_W-1:0]       code_bits,
    input  logic                             q_full,
    output logic                             q_push,
    output sms_pkg::sms_entry_t              q_entry
);

    logic                        match_en;
    logic [sms_pkg::BYTE_W-1:0]  marker_hi;

    // Marker selection from code width
    always_comb
    begin
        match_en  = 1'b1;
        marker_hi = sms_pkg::MARKER_HI_16;
        unique case (code_bits)
            sms_pkg::CODE_13: marker_hi = sms_pkg::MARKER_HI_13;
            sms_pkg::CODE_14,
            sms_pkg::CODE_15: marker_hi = sms_pkg::MARKER_HI_15;
            sms_pkg::CODE_16: marker_hi = sms_pkg::MARKER_HI_16;
            default:
            begin
                match_en  = 1'b0;
                marker_hi = '0;
            end
        endcase
    end

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_entry.word      = s_tdata;
        q_entry.last      = s_tlast;
        q_entry.match_en  = match_en;
        q_entry.marker_hi = marker_hi;
    end

endmodule

// ===== rtl/core/sms_queue.sv =====
// Short register FIFO between front and back ends.
`include "serial_marker_substituter_top_macros.svh"

module sms_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sms_pkg::sms_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output sms_pkg::sms_entry_t pop_entry
);

    sms_pkg::sms_entry_t              slot_reg [sms_pkg::QUEUE_DEPTH];
    logic [sms_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [sms_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [sms_pkg::QCNT_W-1:0]       count_reg, count_next;

    assign full      = (count_reg == sms_pkg::QCNT_W'(sms_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `SMS_ASSERT_IMPL(a_q_pop_nonempty, pop, count_reg != '0, "queue popped while empty")
    `SMS_ASSERT(a_q_count_bound, count_reg <= sms_pkg::QCNT_W'(sms_pkg::QUEUE_DEPTH),
        "queue count overflow")

endmodule

// ===== rtl/core/sms_back.sv =====
// Back end: marker window, compare and substitute, flush and output register.
`include "serial_marker_substituter_top_macros.svh"

module sms_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  sms_pkg::sms_entry_t                q_entry,
    output logic                               q_pop,
    input  logic [sms_pkg::SERIAL_W-1:0]       serial_number,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sms_pkg::WORD_W+sms_pkg::COUNT_W-1:0] m_tdata, // [15:0] out_word,
                                                                 // [31:16] insert_count
    output logic                               m_tlast    // final_word
);

    localparam int MW = sms_pkg::MARKER_WORDS;

    logic [sms_pkg::WORD_W-1:0]   win_reg  [MW];
    logic [sms_pkg::WORD_W-1:0]   win_next [MW];
    logic [sms_pkg::WORD_W-1:0]   cur      [MW];
    logic [sms_pkg::WORD_W-1:0]   subst    [MW];
    logic [sms_pkg::IDX_W-1:0]    fill_reg, fill_next;
    logic [sms_pkg::IDX_W:0]      fill_inc;
    logic                         flush_reg, flush_next;
    logic [sms_pkg::COUNT_W-1:0]  total_reg, total_next, total_inc;
    logic                         out_valid_reg;
    logic [sms_pkg::WORD_W-1:0]   out_word_reg;
    logic                         out_final_reg;
    logic [sms_pkg::COUNT_W-1:0]  out_count_reg;
    logic                         slot_free;
    logic                         hit;
    logic                         load;
    logic [sms_pkg::WORD_W-1:0]   ld_word;
    logic                         ld_final;
    logic [sms_pkg::COUNT_W-1:0]  ld_count;

    assign slot_free = !out_valid_reg || m_tready;
    assign fill_inc  = {1'b0, fill_reg} + 1'b1;
    assign total_inc = (total_reg != sms_pkg::COUNT_MAX) ? total_reg + 1'b1 : total_reg;

    // Window with the incoming word appended, compare and substitution
    always_comb
    begin
        for (int k = 0; k < MW; k++)
        begin
            cur[k] = win_reg[k];
        end
        cur[fill_reg] = q_entry.word;
        hit = q_entry.match_en;
        for (int k = 0; k < MW; k++)
        begin
            if (cur[k] != {q_entry.marker_hi, sms_pkg::marker_letter(sms_pkg::IDX_W'(k))})
            begin
                hit = 1'b0;
            end
        end
        for (int k = 0; k < MW; k++)
        begin
            subst[k] = hit ? {cur[k][sms_pkg::WORD_W-1:sms_pkg::BYTE_W],
                              serial_number[sms_pkg::BYTE_W*k +: sms_pkg::BYTE_W]}
                           : cur[k];
        end
    end

    // Sequencing: flush the window or take one queued word
    always_comb
    begin
        for (int k = 0; k < MW; k++)
        begin
            win_next[k] = win_reg[k];
        end
        fill_next  = fill_reg;
        flush_next = flush_reg;
        total_next = total_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        ld_word    = win_reg[0];
        ld_final   = 1'b0;
        ld_count   = '0;
        if (slot_free)
        begin
            priority if (flush_reg)
            begin
                load    = 1'b1;
                ld_word = win_reg[0];
                for (int k = 0; k < MW - 1; k++)
                begin
                    win_next[k] = win_reg[k + 1];
                end
                fill_next = fill_reg - 1'b1;
                if (fill_reg == sms_pkg::IDX_W'(1))
                begin
                    ld_final   = 1'b1;
                    ld_count   = total_reg;
                    total_next = '0;
                    flush_next = 1'b0;
                end
            end
            else if (q_valid)
            begin
                q_pop = 1'b1;
                if (fill_inc == (sms_pkg::IDX_W + 1)'(MW))
                begin
                    // Full window: compare, emit oldest
                    load    = 1'b1;
                    ld_word = subst[0];
                    for (int k = 0; k < MW - 1; k++)
                    begin
                        win_next[k] = subst[k + 1];
                    end
                    fill_next = sms_pkg::IDX_W'(MW - 1);
                    if (hit)
                    begin
                        total_next = total_inc;
                    end
                    if (q_entry.last)
                    begin
                        flush_next = 1'b1;
                    end
                end
                else if (q_entry.last)
                begin
                    // Short window at end of image: start flushing unchanged
                    load    = 1'b1;
                    ld_word = cur[0];
                    for (int k = 0; k < MW - 1; k++)
                    begin
                        win_next[k] = cur[k + 1];
                    end
                    fill_next = fill_reg;
                    if (fill_reg == '0)
                    begin
                        ld_final   = 1'b1;
                        ld_count   = total_reg;
                        total_next = '0;
                    end
                    else
                    begin
                        flush_next = 1'b1;
                    end
                end
                else
                begin
                    for (int k = 0; k < MW; k++)
                    begin
                        win_next[k] = cur[k];
                    end
                    fill_next = fill_inc[sms_pkg::IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            flush_reg     <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            flush_reg <= flush_next;
            total_reg <= total_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Window and output payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MW; k++)
        begin
            win_reg[k] <= win_next[k];
        end
        if (load)
        begin
            out_word_reg  <= ld_word;
            out_final_reg <= ld_final;
            out_count_reg <= ld_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_word_reg};
    assign m_tlast  = out_final_reg;

    `SMS_ASSERT_IMPL(a_flush_has_words, flush_reg, fill_reg != '0,
        "flush active with empty window")
    `SMS_ASSERT_NEXT(a_final_clears, load && ld_final,
        fill_reg == '0 && total_reg == '0 && !flush_reg, "image state not cleared after final word")
    `SMS_ASSERT_NEXT(a_last_emits, q_pop && q_entry.last, out_valid_reg,
        "last image word produced no output")

endmodule

// ===== rtl/core/serial_marker_substituter_top.sv =====
// Top level of the serial marker substituter: configuration registers and wiring.
//
// Image words stream in and leave in order, MARKER_WORDS - 1 words behind the
// input; each time eight words are held they are compared combinationally with
// the marker chosen by code_bits and, on a match, their low bytes are replaced
// by the serial number bytes. Sustained rate is one word per cycle while
// m_tready is high. After an image's last word the back end drains the words
// still held (up to seven) through the single output register; a four-entry
// queue lets the front end take words until it fills. The final beat carries
// the saturating insert count in tdata[31:16], zero on every other beat. The
// user must write configuration only while idle; the block does not enforce it.
module serial_marker_substituter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sms_pkg::WORD_W-1:0]         s_tdata,   // [15:0] code_word
    input  logic                               s_tlast,   // end_of_image
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sms_pkg::WORD_W+sms_pkg::COUNT_W-1:0] m_tdata, // [15:0] out_word,
                                                                 // [31:16] insert_count
    output logic                               m_tlast,   // final_word
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [sms_pkg::SERIAL_W-1:0]       cfg_data
);

    logic [sms_pkg::CODE_W-1:0]   code_bits_reg;
    logic [sms_pkg::SERIAL_W-1:0] serial_reg;
    logic                         q_full;
    logic                         q_push;
    logic                         q_pop;
    logic                         q_valid;
    sms_pkg::sms_entry_t          push_entry;
    sms_pkg::sms_entry_t          pop_entry;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg <= sms_pkg::CODE_16;
            serial_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sms_pkg::REG_CODE_BITS: code_bits_reg <= cfg_data[sms_pkg::CODE_W-1:0];
                sms_pkg::REG_SERIAL:    serial_reg    <= cfg_data;
                default:                serial_reg    <= serial_reg;
            endcase
        end
    end

    sms_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .code_bits (code_bits_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    sms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    sms_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (pop_entry),
        .q_pop         (q_pop),
        .serial_number (serial_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule
